// ===== rtl/ksort_pkg.sv =====
// Shared widths and defaults for the k-sorted stream sorter.
`default_nettype none
package ksort_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int VALUE_W       = 32;
  localparam int WIN_W         = 6;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1);

endpackage
`default_nettype wire

// ===== rtl/ksort_ram.sv =====
// Generic RAM: one write port and two registered read ports.
`default_nettype none
module ksort_ram #(
  parameter  int WIDTH   = 32,
  parameter  int DEPTH_N = 33,
  localparam int AW      = (DEPTH_N > 1) ? $clog2(DEPTH_N) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH_N];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ksort_heap_ctrl.sv =====
// Heap sequencer: insert with sift-up, pop with sift-down, over the heap RAM.
`default_nettype none
module ksort_heap_ctrl
  import ksort_pkg::*;
#(
  parameter  int DEPTH = DEPTH_DEFAULT,
  localparam int SLOTS = DEPTH + 1,
  localparam int AW    = $clog2(SLOTS),
  localparam int CW    = $clog2(SLOTS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [WIN_W-1:0]   window_size,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               end_of_sequence,
  output logic                    wr_en,
  output logic      [AW-1:0]      wr_addr,
  output logic      [VALUE_W-1:0] wr_data,
  output logic                    rd_en,
  output logic      [AW-1:0]      rd_addr_a,
  output logic      [AW-1:0]      rd_addr_b,
  input  wire logic [VALUE_W-1:0] rd_data_a,
  input  wire logic [VALUE_W-1:0] rd_data_b,
  input  wire logic               out_free,
  output logic                    emit_valid,
  output logic      [VALUE_W-1:0] emit_value,
  output logic                    emit_final
);

  localparam int CHW  = AW + 2;
  localparam int CMPW = (CW > WIN_W) ? CW : WIN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_UP, S_UP_END, S_DECIDE, S_POP_TOP, S_DOWN
  } state_t;

  state_t                      state, state_next;
  logic        [AW-1:0]        pos, pos_next;
  logic        [AW-1:0]        par, par_next;
  logic signed [VALUE_W-1:0]   key, key_next;
  logic        [CW-1:0]        count, count_next;
  logic                        last, last_next;
  logic                        popped, popped_next;

  logic signed [VALUE_W-1:0]   rd_a_s, rd_b_s, min_lk;
  logic        [CMPW-1:0]      win_ext, win_eff;
  logic                        over_window, do_pop;
  logic        [CHW-1:0]       cur_l, cur_r, kid_l, kid_r;
  logic                        cur_l_ok, cur_r_ok, take_l, take_r;
  logic        [AW-1:0]        down_m, kid_base, kid_addr_l, kid_addr_r;

  assign rd_a_s = $signed(rd_data_a);
  assign rd_b_s = $signed(rd_data_b);

  // Effective window saturates at the heap depth
  assign win_ext     = CMPW'(window_size);
  assign win_eff     = (win_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : win_ext;
  assign over_window = CMPW'(count) > win_eff;
  assign do_pop      = last ? (count != '0) : (!popped && over_window);

  // Children of the hole and choice of the smaller one
  assign cur_l    = {1'b0, pos, 1'b1};
  assign cur_r    = cur_l + CHW'(1);
  assign cur_l_ok = cur_l < CHW'(count);
  assign cur_r_ok = cur_r < CHW'(count);
  assign take_l   = cur_l_ok && (rd_a_s < key);
  assign min_lk   = take_l ? rd_a_s : key;
  assign take_r   = cur_r_ok && (rd_b_s < min_lk);

  always_comb begin
    if (take_r) begin
      down_m = AW'(cur_r);
    end else if (take_l) begin
      down_m = AW'(cur_l);
    end else begin
      down_m = pos;
    end
  end

  // Read addresses for the next level down
  assign kid_base   = (state == S_POP_TOP) ? '0 : down_m;
  assign kid_l      = {1'b0, kid_base, 1'b1};
  assign kid_r      = kid_l + CHW'(1);
  assign kid_addr_l = (kid_l < CHW'(count)) ? AW'(kid_l) : '0;
  assign kid_addr_r = (kid_r < CHW'(count)) ? AW'(kid_r) : '0;

  assign in_ready   = (state == S_IDLE);
  assign emit_value = rd_data_a;
  assign emit_final = last && (count == '0);

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    par_next    = par;
    key_next    = key;
    count_next  = count;
    last_next   = last;
    popped_next = popped;
    wr_en       = 1'b0;
    wr_addr     = pos;
    wr_data     = key;
    rd_en       = 1'b0;
    rd_addr_a   = '0;
    rd_addr_b   = '0;
    emit_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_next    = value;
          last_next   = end_of_sequence;
          popped_next = 1'b0;
          pos_next    = AW'(count);
          count_next  = count + CW'(1);
          if (count == '0) begin
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_data    = value;
            state_next = S_DECIDE;
          end else begin
            par_next   = AW'((count - CW'(1)) >> 1);
            rd_en      = 1'b1;
            rd_addr_a  = AW'((count - CW'(1)) >> 1);
            state_next = S_UP;
          end
        end
      end
      S_UP: begin
        wr_en = 1'b1;
        if (rd_a_s > key) begin
          wr_data  = rd_data_a;
          pos_next = par;
          if (par == '0) begin
            state_next = S_UP_END;
          end else begin
            par_next  = (par - AW'(1)) >> 1;
            rd_en     = 1'b1;
            rd_addr_a = (par - AW'(1)) >> 1;
          end
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_UP_END: begin
        wr_en      = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (do_pop) begin
          rd_en       = 1'b1;
          rd_addr_b   = AW'(count - CW'(1));
          count_next  = count - CW'(1);
          popped_next = 1'b1;
          state_next  = S_POP_TOP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP_TOP: begin
        if (out_free) begin
          emit_valid = 1'b1;
          key_next   = rd_b_s;
          pos_next   = '0;
          if (count == '0) begin
            state_next = S_DECIDE;
          end else begin
            rd_en      = 1'b1;
            rd_addr_a  = kid_addr_l;
            rd_addr_b  = kid_addr_r;
            state_next = S_DOWN;
          end
        end
      end
      S_DOWN: begin
        wr_en = 1'b1;
        if (take_l || take_r) begin
          wr_data   = take_r ? rd_data_b : rd_data_a;
          pos_next  = down_m;
          rd_en     = 1'b1;
          rd_addr_a = kid_addr_l;
          rd_addr_b = kid_addr_r;
        end else begin
          state_next = S_DECIDE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      last   <= 1'b0;
      popped <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      last   <= last_next;
      popped <= popped_next;
    end
    pos <= pos_next;
    par <= par_next;
    key <= key_next;
  end

endmodule
`default_nettype wire

// ===== rtl/k_sorted_stream_sorter_core.sv =====
// Top level of the k-sorted stream sorter: window register, heap, output stage.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  input    | in_valid / in_ready     | value, end_of_sequence
//  output   | out_valid / out_ready   | sorted_value, final_res
//  config   | cfg_write_en            | cfg_write_data (window size)
//
// One item at a time: an insert walks up L_up heap levels, each removal
// walks down L_down levels and a decide step closes the item, L being the
// heap levels walked (at most five at DEPTH 32).
// Every level costs one round trip through the heap RAM's read ports.
// A draining end of sequence adds one removal per held value.
// Reset empties the heap by clearing the count; the RAM keeps its contents.
// A stalled output holds the removal sequencer; inputs are taken again
// while the last result still waits in the output register.
`default_nettype none
module k_sorted_stream_sorter_core
  import ksort_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [WIN_W-1:0]   cfg_write_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               end_of_sequence,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [VALUE_W-1:0] sorted_value,
  output logic                    final_res
);

  localparam int SLOTS = DEPTH + 1;
  localparam int AW    = $clog2(SLOTS);

  logic [WIN_W-1:0]   window_size;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr_a, rd_addr_b;
  logic [VALUE_W-1:0] wr_data, rd_data_a, rd_data_b;
  logic               out_free, emit_valid, emit_final;
  logic [VALUE_W-1:0] emit_value;

  // Window register: written directly, no handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_write_en) begin
      window_size <= cfg_write_data;
    end
  end

  // Heap storage: DEPTH+1 slots, the extra one holds the value that
  // overflows the window until it is removed
  ksort_ram #(
    .WIDTH   (VALUE_W),
    .DEPTH_N (SLOTS)
  ) u_heap_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  ksort_heap_ctrl #(
    .DEPTH (DEPTH)
  ) u_heap_ctrl (
    .clk             (clk),
    .rst             (rst),
    .window_size     (window_size),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .value           (value),
    .end_of_sequence (end_of_sequence),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr_a       (rd_addr_a),
    .rd_addr_b       (rd_addr_b),
    .rd_data_a       (rd_data_a),
    .rd_data_b       (rd_data_b),
    .out_free        (out_free),
    .emit_valid      (emit_valid),
    .emit_value      (emit_value),
    .emit_final      (emit_final)
  );

  // Output register: free when empty or being transferred this cycle
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    // load payload on each removal; hold otherwise
    if (emit_valid) begin
      sorted_value <= emit_value;
      final_res    <= emit_final;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ksort_checker.sv =====
// Port-level checks for the k-sorted stream sorter, bound to the top level.
`default_nettype none
module ksort_checker
  import ksort_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               end_of_sequence,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [VALUE_W-1:0] sorted_value,
  input wire logic               final_res
);

  logic [1:0] eos_owed;
  logic       eos_take, final_give;

  assign eos_take   = in_valid && in_ready && end_of_sequence;
  assign final_give = out_valid && out_ready && final_res;

  // Count end-of-sequence transfers whose final result has not left yet;
  // one final may wait in the output register while the next is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      eos_owed <= '0;
    end else begin
      eos_owed <= eos_owed + 2'(eos_take) - 2'(final_give);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sorted_value) && $stable(final_res))
    else $error("output changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle and empty after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an insert is in progress");

  a_final_after_eos: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_res |-> eos_owed != '0)
    else $error("final result without a preceding end of sequence");

endmodule

bind k_sorted_stream_sorter_core ksort_checker u_ksort_checker (.*);
`default_nettype wire
